>>> rtl/core/serial_command_line_interpreter_macros.svh
// ----------------------------------------------------------------------------
// Serial command line interpreter assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_INTERPRETER_MACROS_SVH
`define SERIAL_COMMAND_LINE_INTERPRETER_MACROS_SVH

// The condition must never hold at a clock edge.
`define SCLI_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("scli: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SCLI_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scli: implication violated");

`endif

>>> rtl/core/scli_pkg.sv
// ----------------------------------------------------------------------------
// Serial command line interpreter package
// Sizes, character and event codes, queue item type and decode helpers.
// ----------------------------------------------------------------------------
package scli_pkg;

   localparam int LINE_BUFFER_BYTES = 12;
   localparam int HOLD_MAX          = LINE_BUFFER_BYTES - 1;
   localparam int DIGIT_COUNT       = HOLD_MAX - 1;
   localparam int FILL_W            = $clog2(HOLD_MAX + 1);
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  CHAR_NUL  = 8'h00;
   localparam logic [7:0]  CHAR_TAB  = 8'h09;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [7:0]  CHAR_CR   = 8'h0D;
   localparam logic [31:0] WORD_MASK = 32'h0000_0003;

   typedef enum logic [3:0] {
      EV_ADDR_SET   = 4'd0,
      EV_LENGTH_SET = 4'd1,
      EV_BINARY     = 4'd2,
      EV_LITTLE     = 4'd3,
      EV_BIG        = 4'd4,
      EV_HEX        = 4'd5,
      EV_STARTED    = 4'd6,
      EV_STATS      = 4'd7,
      EV_UNKNOWN    = 4'd8
   } event_type;

   typedef enum logic {
      BK_IDLE  = 1'b0,
      BK_PARSE = 1'b1
   } back_state_type;

   // One executed line as it crosses from the front to the back.
   typedef struct packed {
      event_type                    cmd;
      logic [DIGIT_COUNT-1:0][7:0]  digits;
   } cmd_item_type;

   function automatic event_type classify(input logic [7:0] c);
      event_type ev;
      unique case (c)
         "a", "A": ev = EV_ADDR_SET;
         "l", "L": ev = EV_LENGTH_SET;
         "b", "B": ev = EV_BINARY;
         "e":      ev = EV_LITTLE;
         "E":      ev = EV_BIG;
         "h", "H": ev = EV_HEX;
         "s", "S": ev = EV_STARTED;
         "p", "P": ev = EV_STATS;
         default:  ev = EV_UNKNOWN;
      endcase
      return ev;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
             ((c >= "A") && (c <= "F"));
   endfunction

   // Valid only where is_hex holds; letters have a low nibble of 1 to 6.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (c <= "9") begin
         v = c[3:0];
      end else begin
         v = 4'(c[3:0] + 4'd9);
      end
      return v;
   endfunction

endpackage

>>> rtl/core/scli_if.sv
// ----------------------------------------------------------------------------
// Serial command line interpreter channels
// Valid/ready interfaces for the received byte and the event report.
// ----------------------------------------------------------------------------
interface scli_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scli_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  event_res;
   logic [31:0] start_address_out;
   logic [31:0] readout_length_out;
   logic        hex_output_out;
   logic        little_endian_out;
   logic        readout_active_out;

   modport source (output valid, output event_res, output start_address_out,
                   output readout_length_out, output hex_output_out,
                   output little_endian_out, output readout_active_out,
                   input ready);
   modport sink   (input valid, input event_res, input start_address_out,
                   input readout_length_out, input hex_output_out,
                   input little_endian_out, input readout_active_out,
                   output ready);
endinterface

>>> rtl/core/serial_command_line_interpreter.sv
// ----------------------------------------------------------------------------
// Serial command line interpreter
// Line-oriented command decoder for a serial readout controller.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries                        Transaction
//   req_bus   in         rx_byte                        one received character
//   rsp_bus   out        event_res and current settings one event report
//
// A byte transaction is taken whenever the line queue has space; the queue
// holds two complete lines.
// Simple commands leave the back end in the cycle after they are popped; an
// address or length line first goes through the one-digit-a-cycle hex walk
// over at most ten operand digits.
// Reset is synchronous and active high; it empties the line buffer and the
// queue and clears every readout setting.
// A stalled report holds in the output register while the back end waits
// and the front end keeps collecting bytes while the queue has space.
//
// The front end stores characters into the line buffer and, on CR or LF,
// classifies the line by its first byte and queues the command together with
// the operand bytes. Lines starting with NUL, and empty lines, only clear the
// buffer. The back end executes queued lines, keeps the settings and loads
// the report register.
// ----------------------------------------------------------------------------
`include "serial_command_line_interpreter_macros.svh"

module serial_command_line_interpreter (
   input  logic        clock,
   input  logic        reset,
   scli_req_if.sink    req_bus,
   scli_rsp_if.source  rsp_bus
);

   logic                   push_valid;
   logic                   push_ready;
   scli_pkg::cmd_item_type push_item;
   logic                   pop_valid;
   logic                   pop_ready;
   scli_pkg::cmd_item_type pop_item;

   // Byte collection and command classification.
   scli_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Decoupling queue between the two halves.
   scli_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Command execution and the report register.
   scli_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

   // A completed line must never be offered to a full queue.
   `SCLI_ASSERT_NEVER(a_no_lost_line, push_valid && !push_ready)

   // Reported address and length are always word aligned.
   `SCLI_ASSERT_IMPLIES(a_aligned, rsp_bus.valid,
      (rsp_bus.start_address_out[1:0] == 2'b00) &&
      (rsp_bus.readout_length_out[1:0] == 2'b00))

   // A start report always shows readout as active.
   `SCLI_ASSERT_IMPLIES(a_start_active,
      rsp_bus.valid && (rsp_bus.event_res == scli_pkg::EV_STARTED),
      rsp_bus.readout_active_out)

endmodule

>>> rtl/core/scli_front.sv
// ----------------------------------------------------------------------------
// Serial command line interpreter front end
// Collects received bytes into the line buffer and queues complete lines.
// ----------------------------------------------------------------------------
module scli_front (
   input  logic                  clock,
   input  logic                  reset,
   scli_req_if.sink              req_bus,
   output logic                  push_valid,
   output scli_pkg::cmd_item_type push_item,
   input  logic                  push_ready
);

   logic [scli_pkg::HOLD_MAX-1:0][7:0] line_ff, line_in;
   logic [scli_pkg::FILL_W-1:0]        fill_ff, fill_in;
   logic                               accept;
   logic                               eol;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;
   assign eol           = (req_bus.rx_byte == scli_pkg::CHAR_LF) ||
                          (req_bus.rx_byte == scli_pkg::CHAR_CR);

   // A line whose first byte is NUL (an empty line included) reports nothing.
   assign push_valid       = accept && eol && (line_ff[0] != scli_pkg::CHAR_NUL);
   assign push_item.cmd    = scli_pkg::classify(line_ff[0]);
   assign push_item.digits = line_ff[scli_pkg::HOLD_MAX-1:1];

   always_comb begin
      line_in = line_ff;
      fill_in = fill_ff;
      if (accept) begin
         priority if (req_bus.rx_byte == scli_pkg::CHAR_TAB) begin
            line_in = line_ff;
         end else if (eol) begin
            line_in = '0;
            fill_in = '0;
         end else if (fill_ff < scli_pkg::FILL_W'(scli_pkg::HOLD_MAX)) begin
            for (int i = 0; i < scli_pkg::HOLD_MAX; i++) begin
               if (fill_ff == scli_pkg::FILL_W'(i)) begin
                  line_in[i] = req_bus.rx_byte;
               end
            end
            fill_in = fill_ff + 1'b1;
         end else begin
            // The buffer is full, so the byte is dropped.
            fill_in = fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         fill_ff <= '0;
      end else begin
         line_ff <= line_in;
         fill_ff <= fill_in;
      end
   end

endmodule

>>> rtl/core/scli_queue.sv
// ----------------------------------------------------------------------------
// Serial command line interpreter line queue
// Short first-in first-out store of queued lines between front and back.
// ----------------------------------------------------------------------------
module scli_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  scli_pkg::cmd_item_type push_item,
   output logic                   push_ready,
   output logic                   pop_valid,
   output scli_pkg::cmd_item_type pop_item,
   input  logic                   pop_ready
);

   scli_pkg::cmd_item_type [scli_pkg::QUEUE_DEPTH-1:0] slot_ff;
   logic [scli_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [scli_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [scli_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = (count_ff != scli_pkg::QCNT_W'(scli_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == scli_pkg::QPTR_W'(scli_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == scli_pkg::QPTR_W'(scli_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/scli_back.sv
// ----------------------------------------------------------------------------
// Serial command line interpreter back end
// Executes queued lines, parses hex operands and holds the report register.
// ----------------------------------------------------------------------------
module scli_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  scli_pkg::cmd_item_type pop_item,
   output logic                   pop_ready,
   scli_rsp_if.source             rsp_bus
);

   scli_pkg::back_state_type state_ff, state_in;

   logic [scli_pkg::DIGIT_COUNT-1:0][7:0] digits_ff, digits_in;
   logic [31:0]          acc_ff, acc_in;
   scli_pkg::event_type  cmd_ff, cmd_in;
   scli_pkg::event_type  event_ff, event_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          start_ff, start_in;
   logic [31:0]          length_ff, length_in;
   logic                 hex_ff, hex_in;
   logic                 little_ff, little_in;
   logic                 active_ff, active_in;
   logic                 slot_free;
   logic                 load;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      cmd_in    = cmd_ff;
      event_in  = event_ff;
      start_in  = start_ff;
      length_in = length_ff;
      hex_in    = hex_ff;
      little_in = little_ff;
      active_in = active_ff;
      pop_ready = 1'b0;
      load      = 1'b0;

      unique case (state_ff)
         scli_pkg::BK_IDLE: begin
            pop_ready = slot_free;
            if (pop_valid && slot_free) begin
               if ((pop_item.cmd == scli_pkg::EV_ADDR_SET) ||
                   (pop_item.cmd == scli_pkg::EV_LENGTH_SET)) begin
                  digits_in = pop_item.digits;
                  acc_in    = '0;
                  cmd_in    = pop_item.cmd;
                  state_in  = scli_pkg::BK_PARSE;
               end else begin
                  load     = 1'b1;
                  event_in = pop_item.cmd;
                  unique case (pop_item.cmd)
                     scli_pkg::EV_BINARY:  hex_in    = 1'b0;
                     scli_pkg::EV_HEX:     hex_in    = 1'b1;
                     scli_pkg::EV_LITTLE:  little_in = 1'b1;
                     scli_pkg::EV_BIG:     little_in = 1'b0;
                     scli_pkg::EV_STARTED: active_in = 1'b1;
                     default:              active_in = active_ff;
                  endcase
               end
            end
         end
         scli_pkg::BK_PARSE: begin
            // One digit a cycle; a zero shifted in behind the last held byte
            // always ends the walk.
            if (scli_pkg::is_hex(digits_ff[0])) begin
               acc_in    = {acc_ff[27:0], scli_pkg::hex_value(digits_ff[0])};
               digits_in = {8'h00, digits_ff[scli_pkg::DIGIT_COUNT-1:1]};
            end else if (slot_free) begin
               load     = 1'b1;
               event_in = cmd_ff;
               state_in = scli_pkg::BK_IDLE;
               if (cmd_ff == scli_pkg::EV_ADDR_SET) begin
                  start_in = acc_ff & ~scli_pkg::WORD_MASK;
               end else begin
                  length_in = (acc_ff + scli_pkg::WORD_MASK) & ~scli_pkg::WORD_MASK;
               end
            end
         end
         default: state_in = scli_pkg::BK_IDLE;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scli_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         length_ff    <= '0;
         hex_ff       <= 1'b0;
         little_ff    <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         hex_ff       <= hex_in;
         little_ff    <= little_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      acc_ff    <= acc_in;
      cmd_ff    <= cmd_in;
      event_ff  <= event_in;
   end

   // Settings change only when a report is loaded, so they double as payload.
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.event_res          = event_ff;
   assign rsp_bus.start_address_out  = start_ff;
   assign rsp_bus.readout_length_out = length_ff;
   assign rsp_bus.hex_output_out     = hex_ff;
   assign rsp_bus.little_endian_out  = little_ff;
   assign rsp_bus.readout_active_out = active_ff;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line interpreter testbench
// Sends character streams that form command lines, some well formed and some
// noise, into the interpreter. A local model of the line buffer and of the
// readout settings predicts each event report. Reports are checked field by
// field, in order, while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 5;
   localparam int RANDOM_CHARS     = 670;
   localparam int TAIL_CHARS       = 80;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 40;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   // One event report, as the interpreter should present it.
   typedef struct {
      scli_pkg::event_type ev;
      logic [31:0]         start_address;
      logic [31:0]         readout_length;
      logic                hex_output;
      logic                little_endian;
      logic                readout_active;
   } cli_report_type;

   // One character waiting to be sent. When drain_first is set, the sender
   // holds it back until every outstanding report has been received.
   typedef struct {
      logic [7:0] value;
      bit         drain_first;
   } tx_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scli_req_if req_bus ();
   scli_rsp_if rsp_bus ();

   serial_command_line_interpreter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // -------------------------------------------------------------------------
   // Shared bookkeeping
   // -------------------------------------------------------------------------
   tx_char_type    outgoing_chars[$];
   cli_report_type expected_reports[$];

   int   chars_accepted = 0;     // updated with nonblocking writes only
   int   tail_mark      = 0;
   int   hold_mark      = 0;
   int   lines_executed = 0;
   int   reports_checked = 0;
   int   mismatch_count = 0;
   int   input_stall_cycles = 0;
   int   cycle_count    = 0;
   logic [15:0] events_seen = '0;
   bit   pause_next     = 1'b0;

   logic quiet_tail;
   logic idle_allowed;

   // Towards the end there is no idling at all. Elsewhere, one window of
   // 32 transactions in every 128 runs without idling on either side.
   assign quiet_tail   = (tail_mark != 0) && (chars_accepted >= tail_mark);
   assign idle_allowed = !quiet_tail && (((chars_accepted / 32) % 4) != 3);

   // -------------------------------------------------------------------------
   // Line interpreter model: its own copy of the line buffer and settings.
   // -------------------------------------------------------------------------
   logic [7:0]  held_line [scli_pkg::HOLD_MAX];
   int          held_count    = 0;
   logic [31:0] cur_address   = '0;
   logic [31:0] cur_length    = '0;
   logic        cur_hex       = 1'b0;
   logic        cur_little    = 1'b0;
   logic        cur_active    = 1'b0;

   initial begin
      foreach (held_line[i]) held_line[i] = scli_pkg::CHAR_NUL;
   end

   // Returns 1 and the nibble when the character is a hexadecimal digit.
   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
      nib = 4'd0;
      if (c >= "0" && c <= "9") begin
         nib = 4'(c - "0");
         return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
         nib = 4'(c - "a" + 8'd10);
         return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
         nib = 4'(c - "A" + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Folds one accepted character into the model. A line end executes the
   // held line and, unless the line is empty or starts with NUL, queues the
   // report that the interpreter must produce.
   function automatic void interpret_char(input logic [7:0] c);
      cli_report_type rep;
      logic [31:0] operand;
      logic [3:0]  nib;
      bit          scanning;
      bit          emit;

      if (c == scli_pkg::CHAR_TAB) return;
      if (c != scli_pkg::CHAR_LF && c != scli_pkg::CHAR_CR) begin
         // Characters past the buffer capacity are simply lost.
         if (held_count < scli_pkg::HOLD_MAX) begin
            held_line[held_count] = c;
            held_count++;
         end
         return;
      end

      // The operand is read from the second held byte on; the first byte
      // that is not a hex digit (an unfilled zero included) ends it, and the
      // 32-bit value wraps as digits are shifted in.
      operand  = '0;
      scanning = 1'b1;
      for (int i = 1; i < scli_pkg::HOLD_MAX; i++) begin
         if (scanning) begin
            if (hex_nibble(held_line[i], nib)) operand = {operand[27:0], nib};
            else scanning = 1'b0;
         end
      end

      emit   = 1'b1;
      rep.ev = scli_pkg::EV_UNKNOWN;
      case (held_line[0])
         "a", "A": begin
            cur_address = operand & ~scli_pkg::WORD_MASK;
            rep.ev = scli_pkg::EV_ADDR_SET;
         end
         "l", "L": begin
            cur_length = (operand + 32'd3) & ~scli_pkg::WORD_MASK;
            rep.ev = scli_pkg::EV_LENGTH_SET;
         end
         "b", "B": begin
            cur_hex = 1'b0;
            rep.ev = scli_pkg::EV_BINARY;
         end
         "e": begin
            cur_little = 1'b1;
            rep.ev = scli_pkg::EV_LITTLE;
         end
         "E": begin
            cur_little = 1'b0;
            rep.ev = scli_pkg::EV_BIG;
         end
         "h", "H": begin
            cur_hex = 1'b1;
            rep.ev = scli_pkg::EV_HEX;
         end
         "s", "S": begin
            cur_active = 1'b1;
            rep.ev = scli_pkg::EV_STARTED;
         end
         "p", "P": rep.ev = scli_pkg::EV_STATS;
         scli_pkg::CHAR_NUL: emit = 1'b0;
         default:  rep.ev = scli_pkg::EV_UNKNOWN;
      endcase

      held_count = 0;
      foreach (held_line[i]) held_line[i] = scli_pkg::CHAR_NUL;
      lines_executed++;

      if (emit) begin
         rep.start_address  = cur_address;
         rep.readout_length = cur_length;
         rep.hex_output     = cur_hex;
         rep.little_endian  = cur_little;
         rep.readout_active = cur_active;
         expected_reports.push_back(rep);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Mismatch reporting and report comparison
   // -------------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   task automatic compare_report(input cli_report_type want);
      if (rsp_bus.event_res !== want.ev)
         flag_mismatch("event_res", 32'(want.ev), 32'(rsp_bus.event_res));
      if (rsp_bus.start_address_out !== want.start_address)
         flag_mismatch("start_address_out", want.start_address, rsp_bus.start_address_out);
      if (rsp_bus.readout_length_out !== want.readout_length)
         flag_mismatch("readout_length_out", want.readout_length, rsp_bus.readout_length_out);
      if (rsp_bus.hex_output_out !== want.hex_output)
         flag_mismatch("hex_output_out", 32'(want.hex_output), 32'(rsp_bus.hex_output_out));
      if (rsp_bus.little_endian_out !== want.little_endian)
         flag_mismatch("little_endian_out", 32'(want.little_endian),
                       32'(rsp_bus.little_endian_out));
      if (rsp_bus.readout_active_out !== want.readout_active)
         flag_mismatch("readout_active_out", 32'(want.readout_active),
                       32'(rsp_bus.readout_active_out));
   endtask

   // -------------------------------------------------------------------------
   // Driver: presents the head of the character queue. The prediction is
   // made at the edge where the transaction is accepted, so the model sees
   // exactly the characters that the interpreter took.
   // -------------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= scli_pkg::CHAR_NUL;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            interpret_char(req_bus.rx_byte);
            void'(outgoing_chars.pop_front());
            chars_accepted <= chars_accepted + 1;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // An offered character stays put until it is taken.
            input_stall_cycles++;
         end else if (outgoing_chars.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (outgoing_chars[0].drain_first && expected_reports.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (idle_allowed && $urandom_range(0, 6) == 0) begin
            // This cycle is idle, and send_gap more idle ones follow it.
            send_gap = $urandom_range(0, 7);
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid   <= 1'b1;
            req_bus.rx_byte <= outgoing_chars[0].value;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver hold-off: once, part way through the random stream, the
   // receiver refuses reports for a long stretch so that the line queue
   // fills up and the interpreter has to stall the character input.
   // -------------------------------------------------------------------------
   int long_hold_left = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (!long_hold_done && hold_mark != 0 && chars_accepted >= hold_mark) begin
         long_hold_left <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks each accepted report against the oldest expectation and
   // drives ready with random stall bursts.
   // -------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0)
               flag_mismatch("report with nothing expected, event_res", '0,
                             32'(rsp_bus.event_res));
            else
               compare_report(expected_reports.pop_front());
            reports_checked++;
            if (!$isunknown(rsp_bus.event_res)) events_seen[rsp_bus.event_res] = 1'b1;
         end
         if (long_hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_allowed && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d characters unsent and %0d reports due.",
                  cycle_count, outgoing_chars.size(), expected_reports.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c);
      tx_char_type item;
      item.value       = c;
      item.drain_first = pause_next;
      pause_next       = 1'b0;
      outgoing_chars.push_back(item);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   task automatic push_line(input string s, input logic [7:0] term);
      push_text(s);
      push_char(term);
   endtask

   function automatic logic [7:0] line_end();
      return ($urandom_range(0, 1) != 0) ? scli_pkg::CHAR_CR : scli_pkg::CHAR_LF;
   endfunction

   // Builds one random line. Most lines are real commands with random
   // operands, so that the hex walk and every settings path are exercised;
   // the rest are empty lines, NUL-led lines, unknown commands and noise.
   task automatic queue_random_line();
      string cmd_letters;
      string operand_letters;
      string hex_chars;
      int    kind;
      int    n;
      logic [7:0] lead;

      cmd_letters     = "bBeEhHsSpP";
      operand_letters = "aAlL";
      hex_chars       = "0123456789abcdefABCDEF";
      kind            = $urandom_range(0, 99);

      if (kind < 45) begin
         // Address or length with 0 to 12 digits, sometimes all F or all 0,
         // sometimes with a tab inside the operand or a stray character behind it.
         push_char(operand_letters[$urandom_range(0, 3)]);
         n = $urandom_range(0, 12);
         case ($urandom_range(0, 7))
            0:       for (int i = 0; i < n; i++) push_char("F");
            1:       for (int i = 0; i < n; i++) push_char("0");
            default: for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 15) == 0) push_char(scli_pkg::CHAR_TAB);
               push_char(hex_chars[$urandom_range(0, 21)]);
            end
         endcase
         if ($urandom_range(0, 5) == 0) push_char(8'($urandom_range(32, 126)));
      end else if (kind < 75) begin
         push_char(cmd_letters[$urandom_range(0, 9)]);
         n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 14) : 0;
         for (int i = 0; i < n; i++) push_char(8'($urandom_range(32, 126)));
      end else if (kind < 80) begin
         // Empty line, or one that starts with NUL: the buffer just clears.
         if ($urandom_range(0, 1) != 0) begin
            push_char(scli_pkg::CHAR_NUL);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
         end
      end else if (kind < 88) begin
         do lead = 8'($urandom_range(1, 255));
         while (lead == scli_pkg::CHAR_LF || lead == scli_pkg::CHAR_CR ||
                lead == scli_pkg::CHAR_TAB);
         push_char(lead);
      end else begin
         // Raw noise; any CR or LF inside it ends a line on its own.
         n = $urandom_range(1, 15);
         for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
      end
      push_char(line_end());
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   int directed_chars;
   int line_index;

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = scli_pkg::CHAR_NUL;
      rsp_bus.ready   = 1'b0;

      // Directed part: empty and NUL-led lines, operand extremes and
      // wrap-around, an overlong line, tabs, every command letter and two
      // unknown commands, one of them an all-ones byte.
      push_char(scli_pkg::CHAR_CR);
      push_char(scli_pkg::CHAR_NUL);
      push_line("a1", scli_pkg::CHAR_LF);
      push_line("aFFFFFFFFFFF", scli_pkg::CHAR_CR);
      push_line("LFFFFFFFF", scli_pkg::CHAR_LF);
      push_line("l5", scli_pkg::CHAR_CR);
      push_line("A12c3g9", scli_pkg::CHAR_CR);
      push_line("aDeadBEEF", scli_pkg::CHAR_LF);
      push_line("a", scli_pkg::CHAR_LF);
      push_char(scli_pkg::CHAR_TAB);
      push_text("l");
      push_char(scli_pkg::CHAR_TAB);
      push_line("1F", scli_pkg::CHAR_CR);
      push_line("h", scli_pkg::CHAR_CR);
      push_line("e", scli_pkg::CHAR_CR);
      push_line("s", scli_pkg::CHAR_LF);
      push_line("p", scli_pkg::CHAR_CR);
      push_line("E", scli_pkg::CHAR_CR);
      push_line("b", scli_pkg::CHAR_CR);
      push_line("H", scli_pkg::CHAR_LF);
      push_line("B", scli_pkg::CHAR_LF);
      push_line("S", scli_pkg::CHAR_CR);
      push_line("P", scli_pkg::CHAR_CR);
      push_line("x", scli_pkg::CHAR_CR);
      push_char(8'hFF);
      push_char(scli_pkg::CHAR_CR);
      directed_chars = outgoing_chars.size();

      // Random part. Two lines wait for the interpreter to go quiet before
      // they start, so the sender pauses until all reports are in.
      line_index = 0;
      while (outgoing_chars.size() < directed_chars + RANDOM_CHARS) begin
         if (line_index == 20 || line_index == 110) pause_next = 1'b1;
         queue_random_line();
         line_index++;
      end
      hold_mark = directed_chars + 250;
      tail_mark = outgoing_chars.size() - TAIL_CHARS;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (outgoing_chars.size() != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0)
         flag_mismatch("reports still outstanding", '0, 32'(expected_reports.size()));

      $display("Sent %0d characters making %0d lines; %0d event reports checked.",
               chars_accepted, lines_executed, reports_checked);
      $display("Event codes seen (one bit per code): %b; input held off for %0d cycles.",
               events_seen[8:0], input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/scli_pkg.sv
rtl/core/scli_if.sv
rtl/core/scli_front.sv
rtl/core/scli_queue.sv
rtl/core/scli_back.sv
rtl/core/serial_command_line_interpreter.sv
bench/tb_top.sv
